/* sv/rci_pkg.sv */
// shared types, constants and the square-root step for the ray/circle intersection unit
package rci_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS   = 2'd2
    } rci_reg_t;

    // result classification
    typedef enum logic [1:0] {
        OUT_INSIDE = 2'd0,
        OUT_ENTRY  = 2'd1,
        OUT_AWAY   = 2'd2,
        OUT_BESIDE = 2'd3
    } rci_outcome_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // projection magnitude, radicand, root and partial remainder widths
    localparam int P_W        = 48;
    localparam int RAD_W      = 98;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS = ROOT_W;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } rci_in_t;

    typedef struct packed {
        logic         hit;
        rci_outcome_t outcome;
        logic [31:0]  distance;
    } rci_out_t;

    // data riding alongside the square root
    typedef struct packed {
        rci_outcome_t   outcome;
        logic [P_W-1:0] p;
    } rci_side_t;

    // one stage of the square-root pipeline
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        rci_side_t         side;
    } rci_sq_stage_t;

    // one restoring square-root step: bring down two radicand bits, try root*4+1
    function automatic rci_sq_stage_t rci_sqrt_step(input rci_sq_stage_t s);
        logic [REM_W+1:0] rem_cat;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic             ge;
        rci_sq_stage_t    r;
        rem_cat = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial   = {2'b00, s.root, 2'b01};
        diff    = rem_cat - trial;
        ge      = (rem_cat >= trial);
        r.rem   = ge ? diff[REM_W-1:0] : rem_cat[REM_W-1:0];
        r.root  = {s.root[ROOT_W-2:0], ge};
        r.rad   = {s.rad[RAD_W-3:0], 2'b00};
        r.side  = s.side;
        return r;
    endfunction

endpackage

/* sv/rci_sqrt_pipe.sv */
// pipelined integer square root, one result bit per register stage
module rci_sqrt_pipe
    import rci_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    in_rad,
    input  rci_side_t           in_side,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output rci_side_t           out_side
);

    rci_sq_stage_t             stage_reg  [0:SQRT_STEPS-1];
    rci_sq_stage_t             stage_src  [0:SQRT_STEPS-1];
    rci_sq_stage_t             stage_next [0:SQRT_STEPS-1];
    logic [SQRT_STEPS-1:0]     valid_reg;

    // stage sources: fresh radicand, then the previous stage
    always_comb begin
        stage_src[0].rem  = '0;
        stage_src[0].root = '0;
        stage_src[0].rad  = in_rad;
        stage_src[0].side = in_side;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            stage_src[k] = stage_reg[k-1];
        end
    end

    // one root bit per stage
    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            stage_next[k] = rci_sqrt_step(stage_src[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // valid bits follow the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_root  = stage_reg[SQRT_STEPS-1].root;
    assign out_side  = stage_reg[SQRT_STEPS-1].side;

endmodule

/* sv/ray_circle_intersection_unit.sv */
// ray against circle test: fixed-point entry distance from a 2D ray origin and unit direction
// pipeline from item acceptance to m_valid: 7 arithmetic stages,
//   49 square-root stages of one root bit each, one output register
// throughput: one item per cycle while the output is not stalled; the 49-stage square root sets the depth
// a stalled output freezes the whole pipeline; s_ready follows the output slot
// reset (aresetn low, synchronous) clears all valid bits and the circle registers to zero
module ray_circle_intersection_unit
    import rci_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // ray items in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rci_in_t               s_item,
    // results out
    output logic                  m_valid,
    input  logic                  m_ready,
    output rci_out_t              m_item
);

    logic en;

    // circle registers
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic [30:0]        radius_reg;

    // stage 1: offset from origin to center
    logic               v1_reg;
    logic signed [32:0] ocx_reg, ocy_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic signed [32:0] ocx_next, ocy_next;

    // stage 2: products
    logic               v2_reg;
    logic [65:0]        ax2_reg, ay2_reg;
    logic [61:0]        rr2_reg;
    logic signed [48:0] px_reg, py_reg;
    logic [32:0]        ax_next, ay_next;

    // stage 3: sums
    logic               v3_reg;
    logic [65:0]        len2_3_reg;
    logic [61:0]        rr3_reg;
    logic signed [48:0] proj_reg;

    // stage 4: early tests and partial products of proj squared
    logic               v4_reg, inside4_reg, away4_reg;
    logic [P_W-1:0]     p4_reg;
    logic [47:0]        hh_reg, hl_reg, ll_reg;
    logic [65:0]        len2_4_reg;
    logic [61:0]        rr4_reg;
    logic [P_W-1:0]     p4_next;

    // stage 5: proj squared
    logic               v5_reg, inside5_reg, away5_reg;
    logic [P_W-1:0]     p5_reg;
    logic [95:0]        psq_reg;
    logic [65:0]        len2_5_reg;
    logic [61:0]        rr5_reg;

    // stage 6: right-hand side and scaled length
    logic               v6_reg, inside6_reg, away6_reg;
    logic [P_W-1:0]     p6_reg;
    logic [96:0]        rhs_reg;
    logic [95:0]        len_reg;

    // stage 7: classification and radicand
    logic               v7_reg;
    logic [RAD_W-1:0]   rad7_reg;
    rci_side_t          side7_reg;
    logic [RAD_W-1:0]   diff_next;
    rci_side_t          side7_next;

    // square root output
    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_root;
    rci_side_t          sq_side;

    // output register
    logic               m_valid_reg;
    rci_out_t           m_item_reg;
    rci_out_t           m_item_next;
    logic [P_W-1:0]     t_next;
    logic [P_W-16:0]    d_next;

    // whole pipeline moves when the output slot is free or being emptied
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            radius_reg <= '0;
        end else if (cfg_we) begin
            case (rci_reg_t'(cfg_index))
                REG_CENTER_X: cx_reg     <= cfg_wdata;
                REG_CENTER_Y: cy_reg     <= cfg_wdata;
                REG_RADIUS:   radius_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // valid chain through the arithmetic stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // stage 1
    assign ocx_next = $signed({cx_reg[31], cx_reg}) - $signed({s_item.origin_x[31], s_item.origin_x});
    assign ocy_next = $signed({cy_reg[31], cy_reg}) - $signed({s_item.origin_y[31], s_item.origin_y});

    always_ff @(posedge aclk) begin
        if (en) begin
            ocx_reg <= ocx_next;
            ocy_reg <= ocy_next;
            dx_reg  <= s_item.dir_x;
            dy_reg  <= s_item.dir_y;
        end
    end

    // stage 2: squares of the offset, radius squared, dot product terms
    assign ax_next = ocx_reg[32] ? 33'(-ocx_reg) : 33'(ocx_reg);
    assign ay_next = ocy_reg[32] ? 33'(-ocy_reg) : 33'(ocy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ax2_reg <= 66'(ax_next) * 66'(ax_next);
            ay2_reg <= 66'(ay_next) * 66'(ay_next);
            rr2_reg <= 62'(radius_reg) * 62'(radius_reg);
            px_reg  <= $signed({{16{ocx_reg[32]}}, ocx_reg}) * $signed({{33{dx_reg[15]}}, dx_reg});
            py_reg  <= $signed({{16{ocy_reg[32]}}, ocy_reg}) * $signed({{33{dy_reg[15]}}, dy_reg});
        end
    end

    // stage 3
    always_ff @(posedge aclk) begin
        if (en) begin
            len2_3_reg <= ax2_reg + ay2_reg;
            rr3_reg    <= rr2_reg;
            proj_reg   <= px_reg + py_reg;
        end
    end

    // stage 4: inside and away tests, split proj into 24-bit halves for its square
    assign p4_next = proj_reg[P_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            inside4_reg <= (len2_3_reg <= 66'(rr3_reg));
            away4_reg   <= proj_reg[48];
            p4_reg      <= p4_next;
            hh_reg      <= 48'(p4_next[47:24]) * 48'(p4_next[47:24]);
            hl_reg      <= 48'(p4_next[47:24]) * 48'(p4_next[23:0]);
            ll_reg      <= 48'(p4_next[23:0]) * 48'(p4_next[23:0]);
            len2_4_reg  <= len2_3_reg;
            rr4_reg     <= rr3_reg;
        end
    end

    // stage 5: combine partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            inside5_reg <= inside4_reg;
            away5_reg   <= away4_reg;
            p5_reg      <= p4_reg;
            psq_reg     <= {hh_reg, 48'd0} + {23'd0, hl_reg, 25'd0} + {48'd0, ll_reg};
            len2_5_reg  <= len2_4_reg;
            rr5_reg     <= rr4_reg;
        end
    end

    // stage 6: scale to the common square format
    always_ff @(posedge aclk) begin
        if (en) begin
            inside6_reg <= inside5_reg;
            away6_reg   <= away5_reg;
            p6_reg      <= p5_reg;
            rhs_reg     <= {5'd0, rr5_reg, 30'd0} + {1'b0, psq_reg};
            len_reg     <= {len2_5_reg, 30'd0};
        end
    end

    // stage 7: beside test from the borrow of rhs minus len
    assign diff_next = {1'b0, rhs_reg} - {2'b00, len_reg};

    always_comb begin
        side7_next.p = p6_reg;
        if (inside6_reg) begin
            side7_next.outcome = OUT_INSIDE;
        end else if (away6_reg) begin
            side7_next.outcome = OUT_AWAY;
        end else if (diff_next[RAD_W-1]) begin
            side7_next.outcome = OUT_BESIDE;
        end else begin
            side7_next.outcome = OUT_ENTRY;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad7_reg  <= diff_next[RAD_W-1] ? '0 : diff_next;
            side7_reg <= side7_next;
        end
    end

    // square root of the remaining radicand
    rci_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rad    (rad7_reg),
        .in_side   (side7_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // entry distance: clamp at zero, drop 15 bits, saturate
    assign t_next = (ROOT_W'(sq_side.p) > sq_root) ? P_W'(ROOT_W'(sq_side.p) - sq_root) : '0;
    assign d_next = t_next[P_W-1:15];

    always_comb begin
        m_item_next.outcome  = sq_side.outcome;
        m_item_next.hit      = 1'b0;
        m_item_next.distance = '0;
        case (sq_side.outcome)
            OUT_INSIDE: begin
                m_item_next.hit = 1'b1;
            end
            OUT_ENTRY: begin
                m_item_next.hit      = 1'b1;
                m_item_next.distance = d_next[32] ? 32'hFFFF_FFFF : d_next[31:0];
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* tb/rci_checker.sv */
// result checker for the ray/circle intersection unit: shadows the circle and predicts each ray
`timescale 1ns / 100ps

module rci_checker
    import rci_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  rci_in_t               s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  rci_out_t              m_item,
    output int                    mismatches,
    output int                    results_owed,
    output int                    results_checked,
    output int                    hits_seen
);

    localparam int PRINT_CAP = 60;

    // shadow of the circle registers
    logic signed [31:0] circ_x;
    logic signed [31:0] circ_y;
    logic [30:0]        circ_r;

    rci_out_t awaited_hits[$];
    rci_out_t want;

    initial begin
        mismatches      = 0;
        results_owed    = 0;
        results_checked = 0;
        hits_seen       = 0;
        circ_x          = '0;
        circ_y          = '0;
        circ_r          = '0;
    end

    // exact fixed-point ray/circle test, squares compared in Q.62
    function automatic rci_out_t trace_ray(input rci_in_t ray, input logic signed [31:0] cx,
                                           input logic signed [31:0] cy, input logic [30:0] rad);
        longint       ocx;
        longint       ocy;
        longint       proj;
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] r_w;
        logic [127:0] len_q;
        logic [127:0] rsq_q;
        logic [127:0] rhs_q;
        logic [127:0] rem_q;
        logic [127:0] p_w;
        logic [127:0] c_w;
        logic [63:0]  p;
        logic [63:0]  w;
        logic [63:0]  c;
        logic [63:0]  t;
        logic [63:0]  d;
        rci_out_t     res;
        res.hit      = 1'b0;
        res.outcome  = OUT_INSIDE;
        res.distance = '0;
        ocx   = longint'(cx) - longint'($signed(ray.origin_x));
        ocy   = longint'(cy) - longint'($signed(ray.origin_y));
        ax    = (ocx < 0) ? -ocx : ocx;
        ay    = (ocy < 0) ? -ocy : ocy;
        r_w   = rad;
        len_q = (ax * ax + ay * ay) << 30;
        rsq_q = (r_w * r_w) << 30;
        // origin inside or on the circle
        if (len_q <= rsq_q) begin
            res.hit = 1'b1;
            return res;
        end
        proj = ocx * longint'($signed(ray.dir_x)) + ocy * longint'($signed(ray.dir_y));
        // centre behind the origin
        if (proj < 0) begin
            res.outcome = OUT_AWAY;
            return res;
        end
        p     = proj;
        p_w   = p;
        rhs_q = rsq_q + p_w * p_w;
        // perpendicular distance beyond the radius
        if (len_q > rhs_q) begin
            res.outcome = OUT_BESIDE;
            return res;
        end
        // truncated root of the half-chord squared, one bit at a time
        rem_q = rhs_q - len_q;
        w     = '0;
        for (int i = 63; i >= 0; i--) begin
            c   = w | (64'd1 << i);
            c_w = c;
            if (c_w * c_w <= rem_q)
                w = c;
        end
        t            = (p > w) ? p - w : '0;
        d            = t >> 15;
        res.hit      = 1'b1;
        res.outcome  = OUT_ENTRY;
        res.distance = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // shadow registers, prediction and comparison, all on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            circ_x = '0;
            circ_y = '0;
            circ_r = '0;
            awaited_hits.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CENTER_X: circ_x = cfg_wdata;
                    REG_CENTER_Y: circ_y = cfg_wdata;
                    REG_RADIUS:   circ_r = cfg_wdata[30:0];
                    default: ;
                endcase
            end
            // result side first, so a stray result never pairs with a ray taken this edge
            if (m_valid && m_ready) begin
                if (awaited_hits.size() == 0) begin
                    flag_mismatch("result item with no ray waiting");
                end else begin
                    want = awaited_hits.pop_front();
                    results_checked++;
                    if (want.hit)
                        hits_seen++;
                    if (m_item.hit !== want.hit)
                        flag_mismatch($sformatf("hit %b, expected %b", m_item.hit, want.hit));
                    if (m_item.outcome !== want.outcome)
                        flag_mismatch($sformatf("outcome %0d, expected %0d",
                                                m_item.outcome, want.outcome));
                    if (m_item.distance !== want.distance)
                        flag_mismatch($sformatf("distance %h, expected %h",
                                                m_item.distance, want.distance));
                end
            end
            if (s_valid && s_ready)
                awaited_hits.push_back(trace_ray(s_item, circ_x, circ_y, circ_r));
        end
        results_owed = awaited_hits.size();
    end

endmodule

/* tb/tb.sv */
// testbench top for the ray/circle intersection unit: ray stimulus, result sink and verdict
`timescale 1ns / 100ps

module tb;
    import rci_pkg::*;

    localparam int  HALF_PERIOD  = 4;
    localparam int  RESET_CYCLES = 8;
    localparam int  STALL_LIMIT  = 2000;
    localparam int  DRAIN_CYCLES = 70;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  PHASES       = 6;
    localparam int  PHASE_ITEMS  = 315;
    localparam int  IDLE_PCT     = 21;
    localparam real PI           = 3.14159265358979;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [15:0] D_MIN = 16'h8000;
    localparam logic [15:0] D_MAX = 16'h7FFF;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    rci_in_t               s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rci_out_t              m_item;

    int mismatches;
    int results_owed;
    int results_checked;
    int hits_seen;

    bit calm        = 1'b0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int stall_count = 0;
    int rays_sent   = 0;
    int settings    = 0;

    always #HALF_PERIOD aclk = ~aclk;

    ray_circle_intersection_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    rci_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .mismatches      (mismatches),
        .results_owed    (results_owed),
        .results_checked (results_checked),
        .hits_seen       (hits_seen)
    );

    // result sink: random back-pressure, or a long hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic logic [31:0] q16(input int units);
        return 32'(units * 65536);
    endfunction

    function automatic real frac();
        return real'($urandom) / 4294967296.0;
    endfunction

    // Q1.15 direction at angle a, packed as {dir_x, dir_y}
    function automatic logic [31:0] unit_dir(input real a);
        return {16'(longint'(32767.0 * $cos(a))), 16'(longint'(32767.0 * $sin(a)))};
    endfunction

    function automatic rci_in_t ray_at(input logic [31:0] ox, input logic [31:0] oy,
                                       input logic [15:0] dx, input logic [15:0] dy);
        rci_in_t r;
        r.origin_x = ox;
        r.origin_y = oy;
        r.dir_x    = dx;
        r.dir_y    = dy;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        s_valid   <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS, rad);
        settings++;
    endtask

    // offer one ray, with random gaps ahead of it, and wait until it is taken
    task automatic send_ray(input rci_in_t ray);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= ray;
        do @(posedge aclk); while (!s_ready);
        rays_sent++;
    endtask

    // sender pauses until every result is back, then lets the pipeline settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [31:0] ccx;
        logic [31:0] ccy;
        logic [31:0] crad;
        real         rr;
        real         reach;
        real         ang;
        int          kind;
        rci_in_t     ray;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // circle at reset: zero radius at the origin
        send_ray(ray_at('0, '0, D_MAX, '0));
        send_ray(ray_at(q16(5), '0, D_MAX, '0));
        send_ray(ray_at(q16(-5), '0, D_MAX, '0));
        drain();
        // a write to the spare index must leave the circle alone
        write_reg(REG_SPARE, 32'hDEAD_BEEF);
        send_ray(ray_at('0, '0, D_MIN, D_MIN));
        drain();

        // radius 10 at the origin: every outcome, tangent, zero projection, odd directions
        set_circle('0, '0, q16(10));
        send_ray(ray_at(q16(-20), '0, D_MAX, '0));
        send_ray(ray_at(q16(20), '0, D_MAX, '0));
        send_ray(ray_at(q16(-20), q16(15), D_MAX, '0));
        send_ray(ray_at(q16(20), q16(10), D_MIN, '0));
        send_ray(ray_at('0, '0, '0, D_MAX));
        send_ray(ray_at(q16(10), '0, D_MAX, '0));
        send_ray(ray_at(q16(-20), '0, '0, D_MAX));
        send_ray(ray_at(q16(20), q16(20), D_MIN, D_MIN));
        send_ray(ray_at(q16(-20), '0, 16'd1, '0));
        send_ray(ray_at(q16(-20), '0, '0, '0));
        drain();

        // centre at the most negative corner: far ray saturates the distance
        set_circle(Q_MIN, Q_MIN, q16(1));
        send_ray(ray_at(Q_MAX, Q_MAX, D_MIN, D_MIN));
        send_ray(ray_at(Q_MIN, Q_MIN, D_MAX, D_MIN));
        drain();

        // largest radius, with the bit above the register width set
        set_circle(Q_MAX, Q_MAX, 32'hFFFF_FFFF);
        send_ray(ray_at(Q_MIN, Q_MIN, D_MAX, D_MAX));
        send_ray(ray_at(Q_MIN, Q_MAX, D_MAX, '0));
        send_ray(ray_at('0, '0, D_MAX, D_MAX));
        send_ray(ray_at(Q_MAX, Q_MIN, '0, D_MAX));

        // random phases, one circle each
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    ccx  = q16($urandom_range(200) - 100);
                    ccy  = q16($urandom_range(200) - 100);
                    crad = q16(50);
                end
                1: begin
                    ccx  = $urandom;
                    ccy  = $urandom;
                    crad = $urandom_range(65535, 1);
                end
                2: begin
                    ccx  = q16($urandom_range(200) - 100);
                    ccy  = q16($urandom_range(200) - 100);
                    crad = $urandom_range(q16(2000), q16(1));
                end
                3: begin
                    ccx  = $urandom;
                    ccy  = $urandom;
                    crad = 32'hFFFF_FFFF;
                end
                4: begin
                    ccx  = Q_MAX;
                    ccy  = Q_MIN;
                    crad = q16(3);
                end
                default: begin
                    ccx  = q16($urandom_range(200) - 100);
                    ccy  = q16($urandom_range(200) - 100);
                    crad = $urandom;
                end
            endcase
            set_circle(ccx, ccy, crad);
            rr   = real'(crad[30:0]);
            calm = (ph == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 100)
                    hold_req++;
                kind = $urandom_range(99);
                ang  = 2.0 * PI * frac();
                if (kind < 15) begin
                    // raw noise: any origin, any direction length
                    ray = {$urandom, $urandom, $urandom};
                end else begin
                    if (kind < 30)
                        reach = 0.98 * rr * frac();
                    else
                        reach = rr * (1.0 + 3.0 * frac()) + 65536.0 * frac();
                    ray.origin_x = 32'(longint'($signed(ccx)) + longint'(reach * $cos(ang)));
                    ray.origin_y = 32'(longint'($signed(ccy)) + longint'(reach * $sin(ang)));
                    // mostly aimed back at the centre, some any way at all
                    if (kind >= 30 && kind < 85)
                        {ray.dir_x, ray.dir_y} = unit_dir(ang + PI + 1.6 * (frac() - 0.5));
                    else
                        {ray.dir_x, ray.dir_y} = unit_dir(2.0 * PI * frac());
                end
                send_ray(ray);
            end
            calm = 1'b0;
        end

        drain();
        $display("covered %0d rays over %0d circle settings: extremes, tangent, zero projection,",
                 rays_sent, settings);
        $display("saturation, odd directions, stalls; %0d results checked, %0d hits",
                 results_checked, hits_seen);
        if (mismatches == 0 && results_owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
